### hdl/mlcd_pkg.sv
// Shared types, constants and lookup functions for the mouse-look camera direction block.
package mlcd_pkg;

	// CORDIC iterations per angle; the arctangent table holds 24 entries.
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_COUNT   = 24;

	// Angles in 1/256 degree.
	localparam int FULL_TURN    = 92160;
	localparam int HALF_TURN    = 46080;
	localparam int QUARTER_TURN = 23040;

	// The yaw sum is split into low bits that pass through and a high part reduced modulo 45.
	localparam int YAW_LOW_BITS = 11;
	localparam int YAW_HI_BITS  = 23;
	localparam int YAW_HI_MOD   = FULL_TURN / (1 << YAW_LOW_BITS);
	localparam int YAW_HI_CORR  = (1 << YAW_HI_BITS) % YAW_HI_MOD;

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	// Configuration register indexes.
	localparam logic [1:0] REG_SENSITIVITY = 2'd0;
	localparam logic [1:0] REG_PITCH_LIMIT = 2'd1;

	typedef struct packed {
		logic signed [23:0] pointer_x;
		logic signed [23:0] pointer_y;
	} item_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} result_t;

	// Arctangent of 2^-i in 1/65536 degree, rounded to nearest.
	function automatic logic [21:0] atan_entry(input logic [4:0] idx);
		logic [21:0] v;
		unique case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	// Clamp to the Q1.14 range of a unit vector component.
	function automatic logic signed [15:0] sat_q14(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd16384) begin
			r = 16'sd16384;
		end else if (v < -18'sd16384) begin
			r = -16'sd16384;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

### hdl/mouse_look_camera_direction.sv
// Mouse-look camera: pointer positions in, unit look direction out, via a shared CORDIC unit.
//
// Usage:
// Pointer positions arrive on the item channel (item_valid/item_ready, payload item) and one
// look direction per item leaves on the result channel (result_valid/result_ready, payload
// result). Sensitivity and pitch limit are written through cfg_we/cfg_index/cfg_data while
// the block is idle; writes to unknown indexes are dropped.
// Each item runs through a small sequencer: two sensitivity multiplies, a pitch clamp, a
// pitch CORDIC pass that hides the modulo-360 reduction of the yaw, a yaw CORDIC pass and
// two products for the horizontal components. item_ready is high only while the sequencer
// is idle and rises in the cycle after the result is loaded, so no new item is taken until
// the previous item's result is loaded. The finished result sits in an output register; a
// stalled receiver holds the next result in the last sequencer step, and no further item is
// taken until it moves.
// Reset restores the default sensitivity and pitch limit, sets yaw to -90 degrees, pitch to
// zero and treats the next item as the first one, whose pointer change is zero.
module mouse_look_camera_direction (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  mlcd_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output mlcd_pkg::result_t   result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MULX  = 4'd1;
	localparam logic [3:0] S_MULY  = 4'd2;
	localparam logic [3:0] S_PITCH = 4'd3;
	localparam logic [3:0] S_CORDP = 4'd4;
	localparam logic [3:0] S_YLOAD = 4'd5;
	localparam logic [3:0] S_CORDY = 4'd6;
	localparam logic [3:0] S_MULC  = 4'd7;
	localparam logic [3:0] S_MULS  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	localparam logic signed [17:0] QUARTER18 = 18'(mlcd_pkg::QUARTER_TURN);
	localparam logic signed [17:0] HALF18    = 18'(mlcd_pkg::HALF_TURN);
	localparam logic signed [17:0] FULL18    = 18'(mlcd_pkg::FULL_TURN);
	localparam logic [4:0]         STEPS5    = 5'(mlcd_pkg::CORDIC_STEPS);
	localparam logic [1:0]         MOD_DONE2 = 2'd3;
	localparam logic [12:0]        HIMOD13   = 13'(mlcd_pkg::YAW_HI_MOD);
	// floor(v * 5826 / 2^18) equals floor(v / 45) for every folded value below 10082.
	localparam logic [12:0]        RECIP13   = 13'd5826;
	localparam logic [5:0]         HICORR6   = 6'(mlcd_pkg::YAW_HI_CORR);
	localparam logic [5:0]         HIADD6    =
		6'(mlcd_pkg::YAW_HI_MOD - mlcd_pkg::YAW_HI_CORR);
	localparam logic signed [63:0] ROUND46   = 64'sd1 <<< 46 >>> 1;

	// Control and architectural state
	logic [3:0]         state_q;
	logic [15:0]        sens_q;
	logic [14:0]        plim_q;
	logic [16:0]        yaw_q;
	logic signed [15:0] pitch_q;
	logic signed [23:0] prev_x_q;
	logic signed [23:0] prev_y_q;
	logic               first_q;
	logic               result_valid_q;
	logic [1:0]         mcnt_q;
	logic [4:0]         ccnt_q;

	// Datapath registers
	logic signed [24:0] dx_q;
	logic signed [24:0] dy_q;
	logic signed [63:0] prod_q;
	logic [22:0]        mq_q;
	logic [12:0]        mfold_q;
	logic [7:0]         mquo_q;
	logic [5:0]         mr_q;
	logic               msign_q;
	logic [10:0]        mlow_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic signed [24:0] cz_q;
	logic               cneg_q;
	logic signed [31:0] sp_q;
	logic signed [31:0] cp_q;
	logic signed [31:0] syaw_q;
	logic signed [31:0] cyaw_q;
	logic signed [15:0] dirx_q;
	mlcd_pkg::result_t  result_q;

	logic item_acc;
	logic out_load;
	assign item_ready   = (state_q == S_IDLE);
	assign item_acc     = item_valid && item_ready;
	assign out_load     = (state_q == S_DONE) && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Pointer change; the first item counts as no movement.
	logic signed [24:0] dx_new;
	logic signed [24:0] dy_new;
	assign dx_new = first_q ? 25'sd0 :
		{item.pointer_x[23], item.pointer_x} - {prev_x_q[23], prev_x_q};
	assign dy_new = first_q ? 25'sd0 :
		{prev_y_q[23], prev_y_q} - {item.pointer_y[23], item.pointer_y};

	// Shared multiplier
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p;
	always_comb begin
		unique case (state_q)
			S_MULX: begin
				mul_a = {{7{dx_q[24]}}, dx_q};
				mul_b = {16'b0, sens_q};
			end
			S_MULY: begin
				mul_a = {{7{dy_q[24]}}, dy_q};
				mul_b = {16'b0, sens_q};
			end
			S_MULC: begin
				mul_a = cyaw_q;
				mul_b = cp_q;
			end
			S_MULS: begin
				mul_a = syaw_q;
				mul_b = cp_q;
			end
			default: begin
				mul_a = 32'sd0;
				mul_b = 32'sd0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Scaled angle change in 1/256 degree, rounded half up.
	logic signed [63:0] scl_sum;
	logic signed [33:0] scl;
	assign scl_sum = prod_q + 64'sd128;
	assign scl     = scl_sum[41:8];

	logic signed [33:0] yaw_sum;
	assign yaw_sum = $signed({17'b0, yaw_q}) + scl;

	// Pitch update with clamp; limits above a quarter turn act as a quarter turn.
	logic [14:0]        lim;
	logic signed [34:0] lim_pos;
	logic signed [34:0] pitch_sum;
	logic signed [15:0] pitch_new;
	assign lim       = (plim_q > 15'(mlcd_pkg::QUARTER_TURN)) ?
		15'(mlcd_pkg::QUARTER_TURN) : plim_q;
	assign lim_pos   = $signed({20'b0, lim});
	assign pitch_sum = {{19{pitch_q[15]}}, pitch_q} + {scl[33], scl};
	always_comb begin
		if (pitch_sum > lim_pos) begin
			pitch_new = $signed({1'b0, lim});
		end else if (pitch_sum < -lim_pos) begin
			pitch_new = -$signed({1'b0, lim});
		end else begin
			pitch_new = pitch_sum[15:0];
		end
	end

	// Yaw high part modulo 45: 2^12 is one more than a multiple of 45, so the two halves
	// are summed, then the quotient comes from a reciprocal product and the remainder
	// from one subtraction, one step per cycle.
	logic        mod_done;
	logic [12:0] mod_fold;
	logic [25:0] mod_prod;
	logic [7:0]  mod_quo;
	logic [12:0] mod_rem;
	logic [5:0]  yaw_hi;
	assign mod_done = (mcnt_q == MOD_DONE2);
	assign mod_fold = {2'b0, mq_q[22:12]} + {1'b0, mq_q[11:0]};
	assign mod_prod = {13'b0, mfold_q} * {13'b0, RECIP13};
	assign mod_quo  = mod_prod[25:18];
	assign mod_rem  = mfold_q - 13'(mquo_q * HIMOD13);
	// The top bit of the high part carries negative weight; fold its residue back in.
	always_comb begin
		if (!msign_q) begin
			yaw_hi = mr_q;
		end else if (mr_q >= HICORR6) begin
			yaw_hi = mr_q - HICORR6;
		end else begin
			yaw_hi = mr_q + HIADD6;
		end
	end

	// Yaw angle folded into [-90, +90] degrees for the CORDIC.
	logic signed [17:0] ya;
	logic signed [17:0] ya_red;
	logic               ya_neg;
	assign ya = ($signed({1'b0, yaw_q}) >= HALF18) ?
		$signed({1'b0, yaw_q}) - FULL18 : $signed({1'b0, yaw_q});
	always_comb begin
		if (ya > QUARTER18) begin
			ya_red = HALF18 - ya;
			ya_neg = 1'b1;
		end else if (ya < -QUARTER18) begin
			ya_red = -HALF18 - ya;
			ya_neg = 1'b1;
		end else begin
			ya_red = ya;
			ya_neg = 1'b0;
		end
	end

	// CORDIC rotation unit, one iteration per cycle.
	logic               cordic_run;
	logic               cordic_done;
	logic signed [31:0] cx_sh;
	logic signed [31:0] cy_sh;
	logic signed [24:0] cat;
	assign cordic_done = (ccnt_q == STEPS5);
	assign cordic_run  = ((state_q == S_CORDP) || (state_q == S_CORDY)) && (ccnt_q < STEPS5);
	assign cx_sh       = cx_q >>> ccnt_q;
	assign cy_sh       = cy_q >>> ccnt_q;
	assign cat         = $signed({3'b0, mlcd_pkg::atan_entry(ccnt_q)});

	// Output rounding
	logic signed [63:0] prod_rnd;
	logic signed [32:0] sp_rnd;
	assign prod_rnd = prod_q + ROUND46;
	assign sp_rnd   = {sp_q[31], sp_q} + 33'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sens_q         <= 16'd6554;
			plim_q         <= 15'd22784;
			yaw_q          <= 17'd69120;
			pitch_q        <= 16'sd0;
			prev_x_q       <= 24'sd400;
			prev_y_q       <= 24'sd300;
			first_q        <= 1'b1;
			result_valid_q <= 1'b0;
			mcnt_q         <= MOD_DONE2;
			ccnt_q         <= 5'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == mlcd_pkg::REG_SENSITIVITY) begin
					sens_q <= cfg_data;
				end else if (cfg_index == mlcd_pkg::REG_PITCH_LIMIT) begin
					plim_q <= cfg_data[14:0];
				end
			end
			if (!mod_done) begin
				mcnt_q <= mcnt_q + 2'd1;
			end
			if (cordic_run) begin
				ccnt_q <= ccnt_q + 5'd1;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						prev_x_q <= item.pointer_x;
						prev_y_q <= item.pointer_y;
						first_q  <= 1'b0;
						state_q  <= S_MULX;
					end
				end
				S_MULX: state_q <= S_MULY;
				S_MULY: begin
					mcnt_q  <= 2'd0;
					state_q <= S_PITCH;
				end
				S_PITCH: begin
					pitch_q <= pitch_new;
					ccnt_q  <= 5'd0;
					state_q <= S_CORDP;
				end
				S_CORDP: begin
					if (cordic_done && mod_done) begin
						yaw_q   <= {yaw_hi, mlow_q};
						state_q <= S_YLOAD;
					end
				end
				S_YLOAD: begin
					ccnt_q  <= 5'd0;
					state_q <= S_CORDY;
				end
				S_CORDY: begin
					if (cordic_done) begin
						state_q <= S_MULC;
					end
				end
				S_MULC: state_q <= S_MULS;
				S_MULS: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			dx_q <= dx_new;
			dy_q <= dy_new;
		end
		if ((state_q == S_MULX) || (state_q == S_MULY) ||
			(state_q == S_MULC) || (state_q == S_MULS)) begin
			prod_q <= mul_p;
		end
		if (state_q == S_MULY) begin
			mq_q    <= yaw_sum[33:11];
			msign_q <= yaw_sum[33];
			mlow_q  <= yaw_sum[10:0];
		end
		if (mcnt_q == 2'd0) begin
			mfold_q <= mod_fold;
		end
		if (mcnt_q == 2'd1) begin
			mquo_q <= mod_quo;
		end
		if (mcnt_q == 2'd2) begin
			mr_q <= mod_rem[5:0];
		end
		if (state_q == S_PITCH) begin
			// Pitch never leaves a quarter turn, so it needs no folding.
			cx_q   <= mlcd_pkg::CORDIC_GAIN;
			cy_q   <= 32'sd0;
			cz_q   <= {pitch_new[15], pitch_new, 8'b0};
			cneg_q <= 1'b0;
		end else if (state_q == S_YLOAD) begin
			cx_q   <= mlcd_pkg::CORDIC_GAIN;
			cy_q   <= 32'sd0;
			cz_q   <= {ya_red[16:0], 8'b0};
			cneg_q <= ya_neg;
		end else if (cordic_run) begin
			if (!cz_q[24]) begin
				cx_q <= cx_q - cy_sh;
				cy_q <= cy_q + cx_sh;
				cz_q <= cz_q - cat;
			end else begin
				cx_q <= cx_q + cy_sh;
				cy_q <= cy_q - cx_sh;
				cz_q <= cz_q + cat;
			end
		end
		if ((state_q == S_CORDP) && cordic_done && mod_done) begin
			sp_q <= cy_q;
			cp_q <= cx_q;
		end
		if ((state_q == S_CORDY) && cordic_done) begin
			syaw_q <= cy_q;
			cyaw_q <= cneg_q ? -cx_q : cx_q;
		end
		if (state_q == S_MULS) begin
			dirx_q <= mlcd_pkg::sat_q14(prod_rnd[63:46]);
		end
		if (out_load) begin
			result_q.dir_x <= dirx_q;
			result_q.dir_y <= mlcd_pkg::sat_q14({sp_rnd[32], sp_rnd[32:16]});
			result_q.dir_z <= mlcd_pkg::sat_q14(prod_rnd[63:46]);
		end
	end

`ifndef SYNTHESIS
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		yaw_q < 17'(mlcd_pkg::FULL_TURN))
		else $error("yaw angle left the full turn");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pitch_q <= 16'sd23040) && (pitch_q >= -16'sd23040))
		else $error("pitch angle beyond a quarter turn");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> state_q == S_MULX)
		else $error("accepted item did not start the sequencer");

	a_mod_before_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_YLOAD |-> mod_done)
		else $error("yaw used before its reduction finished");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the final step");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the mouse-look camera direction block.
module tb_top;

	// Indexes past the register list; writes to them must be dropped.
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	// Arctangent of 2^-i in 1/65536 degree.
	localparam longint ATAN_STEP [mlcd_pkg::ATAN_COUNT] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef enum logic [1:0] {ROW_ITEM, ROW_ITEM_PIN_Y, ROW_REG} row_kind_e;

	typedef struct packed {
		row_kind_e          kind;
		logic [1:0]         idx;
		logic [15:0]        data;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [15:0] pin_y;
	} plan_row_t;

	// Rows marked ROW_ITEM_PIN_Y drive the pitch into a full 90 degree clamp, so the
	// vertical component is known outright.
	localparam int PLAN_ROWS = 22;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_ITEM,      2'd0,            16'd0,     24'sd0,     24'sd0,     16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     24'sd10,    -24'sd10,   16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     24'h7FFFFF, 24'h7FFFFF, 16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     24'h800000, 24'h800000, 16'sd0},
		'{ROW_REG, mlcd_pkg::REG_PITCH_LIMIT, 16'hFFFF, 24'sd0, 24'sd0, 16'sd0},
		'{ROW_REG, mlcd_pkg::REG_SENSITIVITY, 16'hFFFF, 24'sd0, 24'sd0, 16'sd0},
		'{ROW_ITEM_PIN_Y, 2'd0,           16'd0,     24'h800000, 24'h7FFFFF, -16'sd16384},
		'{ROW_ITEM_PIN_Y, 2'd0,           16'd0,     24'h7FFFFF, 24'h800000, 16'sd16384},
		'{ROW_ITEM,      2'd0,            16'd0,     24'sd0,     24'sd0,     16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     24'sd1,     24'sd1,     16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     -24'sd1,    -24'sd1,    16'sd0},
		'{ROW_REG,       REG_SPARE_A,     16'd0,     24'sd0,     24'sd0,     16'sd0},
		'{ROW_REG,       REG_SPARE_B,     16'hFFFF,  24'sd0,     24'sd0,     16'sd0},
		'{ROW_ITEM_PIN_Y, 2'd0,           16'd0,     24'h7FFFFF, 24'h800000, 16'sd16384},
		'{ROW_REG, mlcd_pkg::REG_SENSITIVITY, 16'd0, 24'sd0, 24'sd0, 16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     24'sd123456, -24'sd654321, 16'sd0},
		'{ROW_REG, mlcd_pkg::REG_PITCH_LIMIT, 16'd0, 24'sd0, 24'sd0, 16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     24'sd5,     24'sd5,     16'sd0},
		'{ROW_REG, mlcd_pkg::REG_SENSITIVITY, 16'd128, 24'sd0, 24'sd0, 16'sd0},
		'{ROW_REG, mlcd_pkg::REG_PITCH_LIMIT, 16'd23040, 24'sd0, 24'sd0, 16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     24'sd6,     24'sd5,     16'sd0},
		'{ROW_ITEM,      2'd0,            16'd0,     24'sd5,     24'sd6,     16'sd0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	mlcd_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	mlcd_pkg::result_t result;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = 2'd0;
	logic [15:0]       cfg_data = 16'd0;

	// Camera state and register copies as the block should hold them.
	logic [15:0]        pred_sens = 16'd6554;
	logic [14:0]        pred_limit = 15'd22784;
	logic [16:0]        yaw_acc = 17'd69120;
	logic signed [15:0] pitch_acc = 16'sd0;
	logic signed [23:0] last_px = 24'sd400;
	logic signed [23:0] last_py = 24'sd300;
	logic               fresh_start = 1'b1;

	mlcd_pkg::result_t pending_dirs [$];
	mlcd_pkg::result_t want;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      hold_request = 0;
	int      stall_left = 0;
	int      mismatches = 0;
	int      items_sent = 0;
	int      results_checked = 0;
	int      settings_written = 0;

	mouse_look_camera_direction dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		#10_000_000;
		$display("mouse_look_camera_direction verification failed");
		$finish;
	end

	// Pixels times degrees per pixel, brought to 1/256 degree with halves rounded up.
	function automatic longint scaled_turn(input longint delta);
		return (delta * longint'(pred_sens) + 128) >>> 8;
	endfunction

	function automatic logic signed [15:0] clamp_q14(input longint v);
		if (v > 16384) begin
			return 16'sd16384;
		end
		if (v < -16384) begin
			return -16'sd16384;
		end
		return v[15:0];
	endfunction

	// Sine and cosine in Q2.30 of an angle in 1/256 degree within [-180, 180).
	function automatic void rotate(input longint ang, output longint sin_v,
			output longint cos_v);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		bit     mirrored;
		int     i;
		x = mlcd_pkg::CORDIC_GAIN;
		y = 0;
		mirrored = 1'b0;
		if (ang > mlcd_pkg::QUARTER_TURN) begin
			ang = mlcd_pkg::HALF_TURN - ang;
			mirrored = 1'b1;
		end else if (ang < -mlcd_pkg::QUARTER_TURN) begin
			ang = -mlcd_pkg::HALF_TURN - ang;
			mirrored = 1'b1;
		end
		z = ang * 256;
		for (i = 0; i < mlcd_pkg::CORDIC_STEPS && i < mlcd_pkg::ATAN_COUNT; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= ATAN_STEP[i];
			end else begin
				x += ys;
				y -= xs;
				z += ATAN_STEP[i];
			end
		end
		sin_v = y;
		cos_v = mirrored ? -x : x;
	endfunction

	function automatic mlcd_pkg::result_t predict_direction(input mlcd_pkg::item_t it);
		longint  dx;
		longint  dy;
		longint  turned;
		longint  tilt;
		longint  cap;
		longint  yaw_signed;
		longint  sy;
		longint  cy;
		longint  sp;
		longint  cp;
		mlcd_pkg::result_t r;
		if (fresh_start) begin
			last_px = it.pointer_x;
			last_py = it.pointer_y;
			fresh_start = 1'b0;
		end
		dx = longint'(it.pointer_x) - longint'(last_px);
		dy = longint'(last_py) - longint'(it.pointer_y);
		last_px = it.pointer_x;
		last_py = it.pointer_y;

		turned = (longint'(yaw_acc) + scaled_turn(dx)) % mlcd_pkg::FULL_TURN;
		if (turned < 0) begin
			turned += mlcd_pkg::FULL_TURN;
		end
		yaw_acc = turned[16:0];

		cap = (longint'(pred_limit) > mlcd_pkg::QUARTER_TURN) ? mlcd_pkg::QUARTER_TURN
			: longint'(pred_limit);
		tilt = longint'(pitch_acc) + scaled_turn(dy);
		if (tilt > cap) begin
			tilt = cap;
		end
		if (tilt < -cap) begin
			tilt = -cap;
		end
		pitch_acc = tilt[15:0];

		yaw_signed = (yaw_acc >= mlcd_pkg::HALF_TURN)
			? longint'(yaw_acc) - mlcd_pkg::FULL_TURN : longint'(yaw_acc);
		rotate(yaw_signed, sy, cy);
		rotate(longint'(pitch_acc), sp, cp);
		r.dir_x = clamp_q14((cy * cp + (longint'(1) <<< 45)) >>> 46);
		r.dir_y = clamp_q14((sp + (longint'(1) <<< 15)) >>> 16);
		r.dir_z = clamp_q14((sy * cp + (longint'(1) <<< 45)) >>> 46);
		return r;
	endfunction

	// Mostly small hand movements, with some long sweeps, wild jumps and the rails.
	function automatic logic signed [23:0] wander(input logic signed [23:0] from);
		logic signed [23:0] step;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				step = 24'(int'($urandom_range(0, 600)) - 300);
				return from + step;
			end
			6, 7: begin
				step = 24'(int'($urandom_range(0, 140000)) - 70000);
				return from + step;
			end
			8: begin
				return 24'($urandom);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return 24'h800000;
					1: return 24'h7FFFFF;
					2: return 24'h000000;
					default: return 24'hFFFFFF;
				endcase
			end
		endcase
	endfunction

	task automatic compare_field(input string name, input logic signed [15:0] exp_v,
			input logic signed [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	task automatic send_item(input mlcd_pkg::item_t it, input bit pin,
			input logic signed [15:0] y_val);
		int                gap;
		mlcd_pkg::result_t due;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 1;
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		due = predict_direction(it);
		if (pin) begin
			due.dir_y = y_val;
		end
		pending_dirs.push_back(due);
		items_sent++;
	endtask

	task automatic wait_drained;
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_dirs.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mlcd_pkg::REG_SENSITIVITY: pred_sens = val;
			mlcd_pkg::REG_PITCH_LIMIT: pred_limit = val[14:0];
			default: ;
		endcase
		settings_written++;
		@(posedge clk);
	endtask

	// Output side: check each accepted result, then choose ready for the next cycle.
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (pending_dirs.size() == 0) begin
				$error("result with no item outstanding: dir_x %0d, dir_y %0d, dir_z %0d",
					result.dir_x, result.dir_y, result.dir_z);
				mismatches++;
			end else begin
				want = pending_dirs.pop_front();
				compare_field("dir_x", want.dir_x, result.dir_x);
				compare_field("dir_y", want.dir_y, result.dir_y);
				compare_field("dir_z", want.dir_z, result.dir_z);
				results_checked++;
			end
		end
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else if (hold_request > 0) begin
			result_ready <= 1'b0;
			stall_left = hold_request - 1;
			hold_request = 0;
		end else if ($urandom_range(0, 99) < recv_idle_pct) begin
			result_ready <= 1'b0;
			stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	initial begin
		int              row;
		int              seg;
		int              n;
		mlcd_pkg::item_t pos;
		logic [15:0]     sens_val;
		logic [15:0]     lim_val;
		pos = '0;
		send_idle_pct = 36;
		recv_idle_pct = 58;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < PLAN_ROWS; row++) begin
			if (PLAN[row].kind == ROW_REG) begin
				wait_drained();
				write_reg(PLAN[row].idx, PLAN[row].data);
			end else begin
				pos.pointer_x = PLAN[row].px;
				pos.pointer_y = PLAN[row].py;
				send_item(pos, PLAN[row].kind == ROW_ITEM_PIN_Y, PLAN[row].pin_y);
			end
		end

		for (seg = 0; seg < 6; seg++) begin
			wait_drained();
			case (seg / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0: begin
					sens_val = 16'd6554;
					lim_val = 16'd22784;
				end
				1: begin
					sens_val = 16'hFFFF;
					lim_val = 16'd23040;
				end
				2: begin
					sens_val = 16'($urandom);
					lim_val = 16'($urandom_range(0, 32767));
				end
				3: begin
					sens_val = 16'd300;
					lim_val = 16'd0;
				end
				4: begin
					sens_val = 16'd20000;
					lim_val = 16'd11520;
				end
				default: begin
					sens_val = 16'($urandom);
					lim_val = 16'd23040;
				end
			endcase
			write_reg(mlcd_pkg::REG_SENSITIVITY, sens_val);
			write_reg(mlcd_pkg::REG_PITCH_LIMIT, lim_val);
			for (n = 0; n < 334; n++) begin
				// A long output stall backs the block up until it refuses items.
				if (seg == 0 && n == 120) begin
					hold_request = 400;
				end
				if (seg == 1 && n == 150) begin
					wait_drained();
				end
				pos.pointer_x = wander(pos.pointer_x);
				pos.pointer_y = wander(pos.pointer_y);
				send_item(pos, 1'b0, 16'sd0);
			end
		end

		wait_drained();
		repeat (80) @(posedge clk);
		$display("Checked %0d look directions from %0d pointer items across %0d register writes,",
			results_checked, items_sent, settings_written);
		$display("with a slow receiver, a slow sender, full rate and one long output hold-off.");
		if (mismatches == 0 && pending_dirs.size() == 0) begin
			$display("mouse_look_camera_direction verification clean");
		end else begin
			$display("mouse_look_camera_direction verification failed");
		end
		$finish;
	end

endmodule
